### src/tapgrl_pkg.sv
// types and constants shared by the two-axis gimbal controller
`default_nettype none

package tapgrl_pkg;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] gimbal_x;
        logic signed [15:0] gimbal_y;
        logic               rate_limited_x;
        logic               rate_limited_y;
        logic               at_limit_x;
        logic               at_limit_y;
    } t_out_item;

    // pipeline stage load strobes shared by both axes
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_adv;

    typedef enum logic [2:0] {
        CFG_TARGET_X     = 3'd0,
        CFG_TARGET_Y     = 3'd1,
        CFG_GAIN_P       = 3'd2,
        CFG_GAIN_I       = 3'd3,
        CFG_GAIN_D       = 3'd4,
        CFG_RATE_LIMIT   = 3'd5,
        CFG_GIMBAL_LIMIT = 3'd6
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ANGLE_W    = 16;
    localparam int ERR_W      = 17;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int DERIV_W    = 22;

    // divide by ten: (n * 52429) >> 19 is exact for 16 bit n
    localparam logic [16:0] DIV10_MUL   = 17'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam int          QUOT_W      = 13;

endpackage

`default_nettype wire

### src/tapgrl_axis.sv
// one axis of the gimbal controller: error, integral, derivative, gains, rate cut, clamp
`default_nettype none

module tapgrl_axis #(
    parameter int GAIN_FRAC_BITS = 12,
    parameter int INTEGRAL_WIDTH = 32
) (
    input  wire                                            i_clk,
    input  wire                                            i_rst_n,
    input  wire tapgrl_pkg::t_adv                          i_en,
    input  wire logic signed [tapgrl_pkg::ANGLE_W-1:0]     i_target,
    input  wire logic signed [tapgrl_pkg::ANGLE_W-1:0]     i_angle,
    input  wire logic [tapgrl_pkg::GAIN_W-1:0]             i_gain_p,
    input  wire logic [tapgrl_pkg::GAIN_W-1:0]             i_gain_i,
    input  wire logic [tapgrl_pkg::GAIN_W-1:0]             i_gain_d,
    input  wire logic [tapgrl_pkg::LIMIT_W-1:0]            i_rate_limit,
    input  wire logic [tapgrl_pkg::LIMIT_W-1:0]            i_gimbal_limit,
    output logic signed [tapgrl_pkg::ANGLE_W-1:0]          o_gimbal,
    output logic                                           o_rate_limited,
    output logic                                           o_at_limit
);
    import tapgrl_pkg::*;

    localparam int IW = INTEGRAL_WIDTH;
    localparam int PW = ((IW + 17) > (DERIV_W + 17)) ? (IW + 17) : (DERIV_W + 17);
    localparam int SW = PW + 2;
    localparam int DW = SW - GAIN_FRAC_BITS + 2;

    // state: integral, previous error, gimbal position
    logic signed [IW-1:0]      r_integral;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [DERIV_W-1:0] r_deriv;
    logic signed [15:0]        r_pos;
    logic                      r_rl;
    logic                      r_al;
    logic signed [SW-1:0]      r_prod_p;
    logic signed [SW-1:0]      r_prod_i;
    logic signed [SW-1:0]      r_prod_d;

    logic signed [ERR_W-1:0]   err;
    logic signed [ERR_W-1:0]   err_abs;
    logic [32:0]               div_prod;
    logic [QUOT_W-1:0]         quot_mag;
    logic signed [QUOT_W:0]    quot;
    logic signed [IW:0]        integ_sum;
    logic signed [IW-1:0]      n_integral;
    logic signed [ERR_W:0]     err_diff;
    logic signed [DERIV_W-1:0] diff_x;
    logic signed [DERIV_W-1:0] n_deriv;

    logic signed [16:0]        gp_s;
    logic signed [16:0]        gi_s;
    logic signed [16:0]        gd_s;

    logic signed [SW-1:0]      pid_sum;
    logic signed [DW-1:0]      pid_out;
    logic signed [DW-1:0]      delta;
    logic signed [DW-1:0]      rate_w;
    logic signed [16:0]        step;
    logic signed [16:0]        moved;
    logic signed [16:0]        lim_w;
    logic signed [15:0]        n_pos;
    logic                      n_rl;
    logic                      n_al;

    // error, truncated tenth, saturating integral and derivative scaled by ten
    always_comb begin
        err      = ERR_W'(i_target) - ERR_W'(i_angle);
        err_abs  = err[ERR_W-1] ? -err : err;
        div_prod = 33'(err_abs[15:0]) * 33'(DIV10_MUL);
        quot_mag = QUOT_W'(div_prod >> DIV10_SHIFT);
        quot     = err[ERR_W-1] ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
        integ_sum = (IW+1)'(r_integral) + (IW+1)'(quot);
        if (integ_sum[IW] != integ_sum[IW-1]) begin
            n_integral = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            n_integral = integ_sum[IW-1:0];
        end
        err_diff = (ERR_W+1)'(err) - (ERR_W+1)'(r_err);
        diff_x   = DERIV_W'(err_diff);
        n_deriv  = (diff_x <<< 3) + (diff_x <<< 1);
    end

    always_comb begin
        gp_s = $signed({1'b0, i_gain_p});
        gi_s = $signed({1'b0, i_gain_i});
        gd_s = $signed({1'b0, i_gain_d});
    end

    // gain sum, floor scaling, rate cut and deflection clamp
    always_comb begin
        pid_sum = r_prod_p + r_prod_i + r_prod_d;
        pid_out = DW'(pid_sum >>> GAIN_FRAC_BITS);
        delta   = pid_out - DW'(r_pos);
        rate_w  = $signed(DW'({1'b0, i_rate_limit}));
        n_rl    = 1'b0;
        if (delta > rate_w) begin
            step = $signed({2'b00, i_rate_limit});
            n_rl = 1'b1;
        end else if (delta < -rate_w) begin
            step = -$signed({2'b00, i_rate_limit});
            n_rl = 1'b1;
        end else begin
            step = 17'(delta);
        end
        moved = 17'(r_pos) + step;
        lim_w = $signed({2'b00, i_gimbal_limit});
        n_al  = 1'b0;
        if (moved > lim_w) begin
            n_pos = 16'(lim_w);
            n_al  = 1'b1;
        end else if (moved < -lim_w) begin
            n_pos = 16'(-lim_w);
            n_al  = 1'b1;
        end else begin
            n_pos = 16'(moved);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_err      <= '0;
            r_pos      <= '0;
        end else begin
            if (i_en.s2) begin
                r_integral <= n_integral;
                r_err      <= err;
            end
            if (i_en.s4) begin
                r_pos <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_deriv <= n_deriv;
        end
        if (i_en.s3) begin
            r_prod_p <= SW'(gp_s) * SW'(r_err);
            r_prod_i <= SW'(gi_s) * SW'(r_integral);
            r_prod_d <= SW'(gd_s) * SW'(r_deriv);
        end
        if (i_en.s4) begin
            r_rl <= n_rl;
            r_al <= n_al;
        end
    end

    assign o_gimbal       = r_pos;
    assign o_rate_limited = r_rl;
    assign o_at_limit     = r_al;

    // position never leaves the deflection range that was in force
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en.s4 |=> (17'(r_pos) <= $past(lim_w) && 17'(r_pos) >= -$past(lim_w)))
        else $error("gimbal position outside limit");

    // a clamped result sits exactly on one of the limits
    a_clamp_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en.s4 |=> (!r_al || 17'(r_pos) == $past(lim_w) || 17'(r_pos) == -$past(lim_w)))
        else $error("clamp flag without position on limit");

endmodule

`default_nettype wire

### src/two_axis_pid_gimbal_rate_limited.sv
// top level of the two-axis PID gimbal controller with rate limit and clamp
//
// usage:
//   input channel i_valid / o_stall / i_item carries the measured X and Y tilt
//   angles of one control tick; output channel o_valid / i_stall / o_item returns
//   the new gimbal angles with rate-cut and limit flags, one result per item.
//   registers (targets, gains, rate limit, gimbal limit) are written by the user
//   via i_cfg_we / i_cfg_idx / i_cfg_data while no item is in flight (unenforced).
// timing:
//   four register stages: input, error/integral/derivative, gain products,
//   result. one item is taken every cycle while o_stall is low. the per-tick
//   position update in the last stage is the loop that bounds the clock.
// reset:
//   synchronous, active low. clears all stages, integrals, previous errors and
//   gimbal positions, and loads the default gains and limits.
// stall:
//   a stalled result holds; earlier stages keep filling until each holds an
//   item, then o_stall rises.
`default_nettype none

module two_axis_pid_gimbal_rate_limited #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int GAIN_FRAC_BITS  = 12,
    parameter int INTEGRAL_WIDTH  = 32
) (
    input  wire                                        i_clk,
    input  wire                                        i_rst_n,
    input  wire                                        i_valid,
    output logic                                       o_stall,
    input  wire tapgrl_pkg::t_in_item                  i_item,
    output logic                                       o_valid,
    input  wire                                        i_stall,
    output tapgrl_pkg::t_out_item                      o_item,
    input  wire                                        i_cfg_we,
    input  wire logic [tapgrl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tapgrl_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tapgrl_pkg::*;

    localparam int GP_RAW   = 1 << GAIN_FRAC_BITS;
    localparam int GP_RST   = (GP_RAW > 65535) ? 65535 : GP_RAW;
    localparam int GI_RST   = ((1 << GAIN_FRAC_BITS) + 5) / 10;
    localparam int GD_RST   = 1 << (GAIN_FRAC_BITS - 1);
    localparam int RATE_RAW = 2 << ANGLE_FRAC_BITS;
    localparam int RATE_RST = (RATE_RAW > 32767) ? 32767 : RATE_RAW;
    localparam int LIM_RAW  = 35 << ANGLE_FRAC_BITS;
    localparam int LIM_RST  = (LIM_RAW > 32767) ? 32767 : LIM_RAW;

    logic signed [15:0] r_target_x;
    logic signed [15:0] r_target_y;
    logic [15:0]        r_gain_p;
    logic [15:0]        r_gain_i;
    logic [15:0]        r_gain_d;
    logic [14:0]        r_rate_limit;
    logic [14:0]        r_gimbal_limit;

    t_in_item           r_in;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_v4;
    logic               n_v1;
    logic               n_v2;
    logic               n_v3;
    logic               n_v4;

    logic               rdy1;
    logic               rdy2;
    logic               rdy3;
    logic               rdy4;
    logic               in_take;
    logic               out_take;
    t_adv               adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x     <= '0;
            r_target_y     <= '0;
            r_gain_p       <= 16'(GP_RST);
            r_gain_i       <= 16'(GI_RST);
            r_gain_d       <= 16'(GD_RST);
            r_rate_limit   <= 15'(RATE_RST);
            r_gimbal_limit <= 15'(LIM_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TARGET_X:     r_target_x     <= $signed(i_cfg_data);
                CFG_TARGET_Y:     r_target_y     <= $signed(i_cfg_data);
                CFG_GAIN_P:       r_gain_p       <= i_cfg_data;
                CFG_GAIN_I:       r_gain_i       <= i_cfg_data;
                CFG_GAIN_D:       r_gain_d       <= i_cfg_data;
                CFG_RATE_LIMIT:   r_rate_limit   <= i_cfg_data[LIMIT_W-1:0];
                CFG_GIMBAL_LIMIT: r_gimbal_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stage handshake, each stage fills when it is empty or its successor can take its item
    always_comb begin
        out_take = r_v4 && !i_stall;
        rdy4     = !r_v4 || !i_stall;
        rdy3     = !r_v3 || rdy4;
        rdy2     = !r_v2 || rdy3;
        rdy1     = !r_v1 || rdy2;
        o_stall  = !rdy1;
        in_take  = i_valid && rdy1;
        adv.s2   = r_v1 && rdy2;
        adv.s3   = r_v2 && rdy3;
        adv.s4   = r_v3 && rdy4;
        n_v1     = in_take || (r_v1 && !adv.s2);
        n_v2     = adv.s2  || (r_v2 && !adv.s3);
        n_v3     = adv.s3  || (r_v3 && !adv.s4);
        n_v4     = adv.s4  || (r_v4 && !out_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_item;
        end
    end

    tapgrl_axis #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_axis_x (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_target       (r_target_x),
        .i_angle        (r_in.angle_x),
        .i_gain_p       (r_gain_p),
        .i_gain_i       (r_gain_i),
        .i_gain_d       (r_gain_d),
        .i_rate_limit   (r_rate_limit),
        .i_gimbal_limit (r_gimbal_limit),
        .o_gimbal       (o_item.gimbal_x),
        .o_rate_limited (o_item.rate_limited_x),
        .o_at_limit     (o_item.at_limit_x)
    );

    tapgrl_axis #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_axis_y (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (adv),
        .i_target       (r_target_y),
        .i_angle        (r_in.angle_y),
        .i_gain_p       (r_gain_p),
        .i_gain_i       (r_gain_i),
        .i_gain_d       (r_gain_d),
        .i_rate_limit   (r_rate_limit),
        .i_gimbal_limit (r_gimbal_limit),
        .o_gimbal       (o_item.gimbal_y),
        .o_rate_limited (o_item.rate_limited_y),
        .o_at_limit     (o_item.at_limit_y)
    );

    assign o_valid = r_v4;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("pipeline not empty after reset");

    // a taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_v3) |=> !o_valid)
        else $error("result repeated");

    // an item in the product stage moves into an empty result register
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !o_valid) |=> o_valid)
        else $error("result lost in pipeline");

endmodule

`default_nettype wire

### bench/tb_two_axis_pid_gimbal_rate_limited.sv
// testbench for the two-axis PID gimbal controller: directed and random items checked by a scoreboard
`default_nettype none

module tb_two_axis_pid_gimbal_rate_limited;
    import tapgrl_pkg::*;

    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -64'sd2147483648;
    localparam int GAIN_FRAC = 12;
    localparam logic [2:0] CFG_IDX_SPARE = 3'd7;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 90;
    localparam int SATURATE_ITEMS = 60;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in_item i_item;
    logic o_valid;
    logic i_stall;
    t_out_item o_item;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [15:0] i_cfg_data;

    int hold_left;
    bit tx_idle_en;
    bit rx_idle_en;

    class gimbal_tracker;
        longint target[2];
        longint gain_p;
        longint gain_i;
        longint gain_d;
        longint rate_lim;
        longint gim_lim;
        longint integ[2];
        longint prev_err[2];
        longint pos[2];
        t_out_item expected_gimbal[$];
        int mismatches;

        function new();
            target[0] = 0;
            target[1] = 0;
            gain_p = 4096;
            gain_i = 410;
            gain_d = 2048;
            rate_lim = 512;
            gim_lim = 8960;
            for (int a = 0; a < 2; a++) begin
                integ[a] = 0;
                prev_err[a] = 0;
                pos[a] = 0;
            end
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_TARGET_X: target[0] = longint'($signed(data));
                CFG_TARGET_Y: target[1] = longint'($signed(data));
                CFG_GAIN_P: gain_p = longint'(data);
                CFG_GAIN_I: gain_i = longint'(data);
                CFG_GAIN_D: gain_d = longint'(data);
                CFG_RATE_LIMIT: rate_lim = longint'(data[14:0]);
                CFG_GIMBAL_LIMIT: gim_lim = longint'(data[14:0]);
                default: ;
            endcase
        endfunction

        function void step_axis(int ax, logic signed [15:0] angle,
                                output logic signed [15:0] gim, output logic rl,
                                output logic al);
            longint err;
            longint acc;
            longint deriv;
            longint sum;
            longint pid_out;
            longint delta;
            longint np;
            err = target[ax] - longint'(angle);
            acc = integ[ax] + err / 10;
            if (acc > INTEG_MAX) acc = INTEG_MAX;
            if (acc < INTEG_MIN) acc = INTEG_MIN;
            deriv = (err - prev_err[ax]) * 10;
            sum = gain_p * err + gain_i * acc + gain_d * deriv;
            pid_out = sum >>> GAIN_FRAC;
            delta = pid_out - pos[ax];
            rl = 1'b0;
            if (delta > rate_lim) begin
                delta = rate_lim;
                rl = 1'b1;
            end else if (delta < -rate_lim) begin
                delta = -rate_lim;
                rl = 1'b1;
            end
            np = pos[ax] + delta;
            al = 1'b0;
            if (np > gim_lim) begin
                np = gim_lim;
                al = 1'b1;
            end else if (np < -gim_lim) begin
                np = -gim_lim;
                al = 1'b1;
            end
            integ[ax] = acc;
            prev_err[ax] = err;
            pos[ax] = np;
            gim = np[15:0];
        endfunction

        function void note_tick(t_in_item it);
            t_out_item e;
            logic signed [15:0] gx;
            logic signed [15:0] gy;
            logic rlx;
            logic rly;
            logic alx;
            logic aly;
            step_axis(0, it.angle_x, gx, rlx, alx);
            step_axis(1, it.angle_y, gy, rly, aly);
            e.gimbal_x = gx;
            e.gimbal_y = gy;
            e.rate_limited_x = rlx;
            e.rate_limited_y = rly;
            e.at_limit_x = alx;
            e.at_limit_y = aly;
            expected_gimbal.push_back(e);
        endfunction

        function void compare_field(string field, logic signed [15:0] e,
                                    logic signed [15:0] a);
            if (a !== e) begin
                $display("%0t %s expected %0d actual %0d", $time, field, e, a);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (expected_gimbal.size() == 0) begin
                $display("%0t unexpected result expected none actual %h", $time, got);
                mismatches++;
                return;
            end
            e = expected_gimbal.pop_front();
            compare_field("gimbal_x", e.gimbal_x, got.gimbal_x);
            compare_field("gimbal_y", e.gimbal_y, got.gimbal_y);
            compare_field("rate_limited_x", e.rate_limited_x, got.rate_limited_x);
            compare_field("rate_limited_y", e.rate_limited_y, got.rate_limited_y);
            compare_field("at_limit_x", e.at_limit_x, got.at_limit_x);
            compare_field("at_limit_y", e.at_limit_y, got.at_limit_y);
        endfunction

        function int pending();
            return expected_gimbal.size();
        endfunction
    endclass

    gimbal_tracker tracker;

    two_axis_pid_gimbal_rate_limited u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    initial begin : rx_side
        int burst;
        burst = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 3);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) tracker.check_result(o_item);
    end

    function automatic t_in_item pack_angles(logic signed [15:0] x, logic signed [15:0] y);
        t_in_item it;
        it.angle_x = x;
        it.angle_y = y;
        return it;
    endfunction

    // mostly angles near the target, the rest anywhere in range
    function automatic t_in_item rand_tick();
        t_in_item it;
        int ax;
        int ay;
        if ($urandom_range(0, 9) < 6) begin
            ax = int'(tracker.target[0]) + int'($urandom_range(0, 1023)) - 512;
            ay = int'(tracker.target[1]) + int'($urandom_range(0, 1023)) - 512;
            it.angle_x = ax[15:0];
            it.angle_y = ay[15:0];
        end else begin
            it = $urandom;
        end
        return it;
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 8191));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_angle_limit();
        case ($urandom_range(0, 5))
            0: return 15'd0;
            1: return 15'd23040;
            2, 3: return 15'($urandom_range(0, 2048));
            default: return 15'($urandom_range(0, 23040));
        endcase
    endfunction

    task automatic drive_tick(t_in_item it);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        tracker.note_tick(it);
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_config(logic signed [15:0] tx, logic signed [15:0] ty,
                               logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                               logic [14:0] rate, logic [14:0] lim);
        write_reg(CFG_TARGET_X, tx);
        write_reg(CFG_TARGET_Y, ty);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_RATE_LIMIT, {1'b0, rate});
        write_reg(CFG_GIMBAL_LIMIT, {1'b0, lim});
        end_writes();
    endtask

    task automatic random_config();
        int tx;
        int ty;
        tx = int'($urandom_range(0, 46080)) - 23040;
        ty = int'($urandom_range(0, 46080)) - 23040;
        load_config(tx[15:0], ty[15:0], pick_gain(), pick_gain(), pick_gain(),
                    pick_angle_limit(), pick_angle_limit());
    endtask

    initial begin : stimulus
        t_in_item it;
        tracker = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        hold_left = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults, angle extremes
        drive_tick(pack_angles(16'sd0, 16'sd0));
        drive_tick(pack_angles(16'sh7FFF, 16'sh8000));
        drive_tick(pack_angles(16'sh8000, 16'sh7FFF));
        drive_tick(pack_angles(-16'sd1, 16'sd1));
        drive_tick(pack_angles(16'sh8000, 16'sh8000));
        drive_tick(pack_angles(16'sh7FFF, 16'sh7FFF));
        settle_block();

        // widest error, deflection clamp, spare register index ignored
        load_config(16'sd23040, -16'sd23040, 16'hFFFF, 16'd0, 16'd0, 15'd23040, 15'd1024);
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        end_writes();
        drive_tick(pack_angles(16'sh8000, 16'sh7FFF));
        drive_tick(pack_angles(16'sh8000, 16'sh7FFF));
        drive_tick(pack_angles(16'sd0, 16'sd0));
        drive_tick(pack_angles(16'sh7FFF, 16'sh8000));
        settle_block();

        // zero rate and zero limit hold the gimbal at zero
        load_config(-16'sd23040, 16'sd23040, 16'd4096, 16'hFFFF, 16'hFFFF, 15'd0, 15'd0);
        drive_tick(pack_angles(16'sh7FFF, 16'sh8000));
        drive_tick(pack_angles(16'sh8000, 16'sh7FFF));
        drive_tick(pack_angles(16'sd100, -16'sd100));
        drive_tick(pack_angles(16'sd0, 16'sd0));
        settle_block();
        load_config(16'sd0, 16'sd0, 16'hFFFF, 16'd0, 16'hFFFF, 15'd23040, 15'd0);
        drive_tick(pack_angles(16'sh7FFF, 16'sh8000));
        drive_tick(pack_angles(16'sh8000, 16'sh7FFF));
        drive_tick(pack_angles(16'sd5, -16'sd5));
        settle_block();

        // change equal to the rate and position equal to the limit are not cut
        load_config(16'sd0, 16'sd0, 16'd4096, 16'd0, 16'd0, 15'd256, 15'd512);
        drive_tick(pack_angles(-16'sd256, 16'sd256));
        drive_tick(pack_angles(-16'sd512, 16'sd512));
        drive_tick(pack_angles(-16'sd1024, 16'sd1024));
        settle_block();

        load_config(16'sd23040, -16'sd23040, 16'd0, 16'd0, 16'd0, 15'd23040, 15'd23040);
        drive_tick(pack_angles(16'sd1, -16'sd1));
        drive_tick(pack_angles(16'sh7FFF, 16'sh8000));
        settle_block();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            random_config();
            tx_idle_en = (ph % 4) != 2;
            rx_idle_en = (ph % 4) != 2;
            if (ph == 3) begin
                @(posedge i_clk);
                hold_left = 60;
                @(negedge i_clk);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == PHASE_ITEMS / 2) settle_block();
                drive_tick(rand_tick());
            end
            settle_block();
        end

        // hold both errors at their extremes so the integrals keep growing, then back off
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        load_config(16'sd23040, -16'sd23040, 16'd4096, 16'd410, 16'd2048, 15'd512, 15'd8960);
        it = pack_angles(16'sh8000, 16'sh7FFF);
        for (int n = 0; n < SATURATE_ITEMS; n++) drive_tick(it);
        for (int n = 0; n < 40; n++) drive_tick(rand_tick());

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.pending() != 0)
            $display("%0t %0d results never arrived", $time, tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
